// ===== design/als_pkg.sv =====
// shared types, codes and constants for the addressable led serializer
// no dependencies; imported by every module of the block
package als_pkg;

    // default chain length and pixel format
    localparam int LED_TOTAL_DEF = 3;
    localparam int PIXEL_W       = 24;
    localparam int BITS_PER_LED  = 24;
    localparam logic [4:0] BIT_LAST = 5'(BITS_PER_LED - 1);
    localparam int QUEUE_DEPTH   = 2;

    // register reset values
    localparam logic [7:0]  ZERO_HIGH_RST = 8'd3;
    localparam logic [7:0]  ZERO_LOW_RST  = 8'd9;
    localparam logic [7:0]  ONE_HIGH_RST  = 8'd9;
    localparam logic [7:0]  ONE_LOW_RST   = 8'd3;
    localparam logic [15:0] LATCH_GAP_RST = 16'd1000;

    // request kind codes
    localparam logic [1:0] KIND_SET     = 2'd0;
    localparam logic [1:0] KIND_REFRESH = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // register index codes
    typedef enum logic [2:0] {
        REG_ZERO_HIGH = 3'd0,
        REG_ZERO_LOW  = 3'd1,
        REG_ONE_HIGH  = 3'd2,
        REG_ONE_LOW   = 3'd3,
        REG_LATCH_GAP = 3'd4
    } reg_idx_t;

    // classified operation handed from front to engine
    typedef enum logic [1:0] {
        OP_SET,
        OP_REFRESH,
        OP_TICK,
        OP_BAD
    } op_t;

    // line phase of the engine
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic rejected;
        logic frame_done;
    } out_item_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         led_index;
        logic [PIXEL_W-1:0] word;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  zero_high;
        logic [7:0]  zero_low;
        logic [7:0]  one_high;
        logic [7:0]  one_low;
        logic [15:0] latch_gap;
    } cfg_t;

    // a zero duration counts as one tick
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

// ===== design/als_front.sv =====
// request front end: classifies requests and packs pixels in grb order
// depends on als_pkg
module als_front #(
    parameter int LED_TOTAL = als_pkg::LED_TOTAL_DEF
) (
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  als_pkg::in_item_t cmd_data,
    input  logic             q_full,
    output logic             q_push,
    output als_pkg::cmd_t    q_data
);
    import als_pkg::*;

    // accept whenever the queue has room
    assign cmd_ready = !q_full;
    assign q_push    = cmd_valid && cmd_ready;

    // classify request, bad index folds into the bad op
    always_comb
    begin
        q_data.led_index = cmd_data.led_index;
        q_data.word      = {cmd_data.green, cmd_data.red, cmd_data.blue};
        case (cmd_data.kind)
            KIND_SET:
            begin
                if ({1'b0, cmd_data.led_index} < 9'(LED_TOTAL))
                    q_data.op = OP_SET;
                else
                    q_data.op = OP_BAD;
            end
            KIND_REFRESH: q_data.op = OP_REFRESH;
            KIND_TICK:    q_data.op = OP_TICK;
            default:      q_data.op = OP_BAD;
        endcase
    end

endmodule

// ===== design/als_queue.sv =====
// two-entry queue between the front end and the engine
// depends on als_pkg
module als_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  als_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output als_pkg::cmd_t pop_data
);
    import als_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full      = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // occupancy follows push and pop
    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && not_empty))
            count_next = count_reg + 1'b1;
        else if (!push && pop && not_empty)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && not_empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/als_engine.sv =====
// engine: pixel store, bit timing and frame sequencing, result register
// depends on als_pkg
module als_engine #(
    parameter int LED_TOTAL = als_pkg::LED_TOTAL_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  als_pkg::cmd_t      q_data,
    output logic               q_pop,
    input  als_pkg::cfg_t      cfg,
    output logic               res_valid,
    input  logic               res_ready,
    output als_pkg::out_item_t res_data
);
    import als_pkg::*;

    localparam int ADDR_W = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
    localparam int LED_W  = $clog2(LED_TOTAL + 1);

    // pixel memory with valid bits standing in for the cleared store
    logic [PIXEL_W-1:0]   pixel_mem [LED_TOTAL];
    logic [LED_TOTAL-1:0] valid_reg;
    logic [PIXEL_W-1:0]   rd_word_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 mem_we;

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic [4:0]         bit_reg, bit_next;
    logic [15:0]        tc_reg, tc_next;
    logic [PIXEL_W-1:0] word_reg, word_next;
    logic [15:0]        tc_dec;
    logic [LED_W-1:0]   led_plus;
    logic               busy;
    logic               exec;
    logic               rejected;
    logic               done;

    logic      res_valid_reg;
    out_item_t res_data_reg;

    assign busy     = (phase_reg != PH_IDLE);
    assign exec     = q_valid && (!res_valid_reg || res_ready);
    assign q_pop    = exec;
    assign tc_dec   = (tc_reg != 16'd0) ? tc_reg - 16'd1 : 16'd0;
    assign led_plus = led_reg + 1'b1;
    assign wr_addr  = q_data.led_index[ADDR_W-1:0];

    // prefetch the next led while sending, led zero otherwise
    always_comb
    begin
        if ((phase_reg == PH_HIGH || phase_reg == PH_LOW) &&
            (led_plus < LED_W'(LED_TOTAL)))
            rd_addr = led_plus[ADDR_W-1:0];
        else
            rd_addr = '0;
    end

    // memory write and registered read with write forwarding
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pixel_mem[wr_addr] <= q_data.word;
        if (mem_we && wr_addr == rd_addr)
            rd_word_reg <= q_data.word;
        else if (valid_reg[rd_addr])
            rd_word_reg <= pixel_mem[rd_addr];
        else
            rd_word_reg <= '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (mem_we)
            valid_reg[wr_addr] <= 1'b1;
    end

    // next state and result fields
    always_comb
    begin
        phase_next = phase_reg;
        led_next   = led_reg;
        bit_next   = bit_reg;
        tc_next    = tc_reg;
        word_next  = word_reg;
        mem_we     = 1'b0;
        rejected   = 1'b0;
        done       = 1'b0;
        if (exec)
        begin
            unique case (q_data.op)
                OP_SET:
                begin
                    if (busy)
                        rejected = 1'b1;
                    else
                        mem_we = 1'b1;
                end
                OP_REFRESH:
                begin
                    if (busy)
                        rejected = 1'b1;
                    else
                    begin
                        led_next   = '0;
                        bit_next   = '0;
                        word_next  = rd_word_reg;
                        phase_next = PH_HIGH;
                        tc_next    = at_least_one(rd_word_reg[PIXEL_W-1] ?
                                         {8'h00, cfg.one_high} : {8'h00, cfg.zero_high});
                    end
                end
                OP_TICK:
                begin
                    if (busy)
                    begin
                        tc_next = tc_dec;
                        if (tc_dec == 16'd0)
                        begin
                            unique case (phase_reg)
                                PH_HIGH:
                                begin
                                    phase_next = PH_LOW;
                                    tc_next    = at_least_one(word_reg[PIXEL_W-1] ?
                                                     {8'h00, cfg.one_low} :
                                                     {8'h00, cfg.zero_low});
                                end
                                PH_LOW:
                                begin
                                    if (bit_reg == BIT_LAST)
                                    begin
                                        bit_next  = '0;
                                        led_next  = led_plus;
                                        word_next = rd_word_reg;
                                    end
                                    else
                                    begin
                                        bit_next  = bit_reg + 1'b1;
                                        word_next = {word_reg[PIXEL_W-2:0], 1'b0};
                                    end
                                    if (led_next >= LED_W'(LED_TOTAL))
                                    begin
                                        phase_next = PH_GAP;
                                        tc_next    = at_least_one(cfg.latch_gap);
                                    end
                                    else
                                    begin
                                        phase_next = PH_HIGH;
                                        tc_next    = at_least_one(word_next[PIXEL_W-1] ?
                                                         {8'h00, cfg.one_high} :
                                                         {8'h00, cfg.zero_high});
                                    end
                                end
                                PH_GAP:
                                begin
                                    phase_next = PH_IDLE;
                                    led_next   = '0;
                                    bit_next   = '0;
                                    done       = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: rejected = 1'b1;
            endcase
        end
    end

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            led_reg   <= '0;
            bit_reg   <= '0;
            tc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            led_reg   <= led_next;
            bit_reg   <= bit_next;
            tc_reg    <= tc_next;
        end
    end

    // shift word of the led being sent
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // result register, holds while the consumer stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (exec)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_data_reg.line_level <= (phase_next == PH_HIGH);
            res_data_reg.busy_res   <= (phase_next != PH_IDLE);
            res_data_reg.rejected   <= rejected;
            res_data_reg.frame_done <= done;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== design/addressable_led_serializer.sv =====
// top level: apb timing registers, front end, queue and engine
// depends on als_pkg, als_front, als_queue, als_engine
//
// path: an accepted request is registered in the queue, then executed by the engine
// into the engine result register, which holds it while the consumer stalls
// throughput: one request per cycle while the consumer takes results, one engine step each
// reset: pixel store reads as zero at once through per-led valid bits,
// timing registers return to their defaults, line low and idle
module addressable_led_serializer #(
    parameter int LED_TOTAL = als_pkg::LED_TOTAL_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  als_pkg::in_item_t  cmd_data,
    output logic               res_valid,
    input  logic               res_ready,
    output als_pkg::out_item_t res_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import als_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_we;
    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_not_empty;
    cmd_t     q_in;
    cmd_t     q_out;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    // timing register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high <= ZERO_HIGH_RST;
            cfg_reg.zero_low  <= ZERO_LOW_RST;
            cfg_reg.one_high  <= ONE_HIGH_RST;
            cfg_reg.one_low   <= ONE_LOW_RST;
            cfg_reg.latch_gap <= LATCH_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                REG_ZERO_HIGH: cfg_reg.zero_high <= pwdata[7:0];
                REG_ZERO_LOW:  cfg_reg.zero_low  <= pwdata[7:0];
                REG_ONE_HIGH:  cfg_reg.one_high  <= pwdata[7:0];
                REG_ONE_LOW:   cfg_reg.one_low   <= pwdata[7:0];
                REG_LATCH_GAP: cfg_reg.latch_gap <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_ZERO_HIGH: prdata = {24'h0, cfg_reg.zero_high};
            REG_ZERO_LOW:  prdata = {24'h0, cfg_reg.zero_low};
            REG_ONE_HIGH:  prdata = {24'h0, cfg_reg.one_high};
            REG_ONE_LOW:   prdata = {24'h0, cfg_reg.one_low};
            REG_LATCH_GAP: prdata = {16'h0, cfg_reg.latch_gap};
            default:       prdata = 32'h0;
        endcase
    end

    // request classification
    als_front #(
        .LED_TOTAL (LED_TOTAL)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // decoupling queue
    als_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    // pixel store and line sequencer
    als_engine #(
        .LED_TOTAL (LED_TOTAL)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
